// ===== rtl/vmmio_pkg.sv =====
package vmmio_pkg;

   localparam int NUM_QUEUES_DEFAULT = 8;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_RAISE = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_LEGACY_MODE    = 3'd0,
      CSR_DEVICE_ID      = 3'd1,
      CSR_DEV_FEAT_LOW   = 3'd2,
      CSR_DEV_FEAT_HIGH  = 3'd3,
      CSR_QUEUE_SIZE_MAX = 3'd4
   } csr_index_type;

   localparam logic [31:0] MMIO_MAGIC     = 32'h7472_6976;
   localparam logic [31:0] VERSION_LEGACY = 32'd1;
   localparam logic [31:0] VERSION_MODERN = 32'd2;

   // status byte bit that the driver sets once features are agreed
   localparam int STATUS_FEATURES_OK = 3;

   localparam logic [8:0] OFF_MAGIC          = 9'h000;
   localparam logic [8:0] OFF_VERSION        = 9'h004;
   localparam logic [8:0] OFF_DEVICE_ID      = 9'h008;
   localparam logic [8:0] OFF_VENDOR_ID      = 9'h00c;
   localparam logic [8:0] OFF_DEV_FEAT       = 9'h010;
   localparam logic [8:0] OFF_DEV_FEAT_SEL   = 9'h014;
   localparam logic [8:0] OFF_DRV_FEAT       = 9'h020;
   localparam logic [8:0] OFF_DRV_FEAT_SEL   = 9'h024;
   localparam logic [8:0] OFF_GUEST_PAGE_SZ  = 9'h028;
   localparam logic [8:0] OFF_QUEUE_SEL      = 9'h030;
   localparam logic [8:0] OFF_QUEUE_NUM_MAX  = 9'h034;
   localparam logic [8:0] OFF_QUEUE_NUM      = 9'h038;
   localparam logic [8:0] OFF_QUEUE_ALIGN    = 9'h03c;
   localparam logic [8:0] OFF_QUEUE_PFN      = 9'h040;
   localparam logic [8:0] OFF_QUEUE_READY    = 9'h044;
   localparam logic [8:0] OFF_QUEUE_NOTIFY   = 9'h050;
   localparam logic [8:0] OFF_INT_STATUS     = 9'h060;
   localparam logic [8:0] OFF_INT_ACK        = 9'h064;
   localparam logic [8:0] OFF_STATUS         = 9'h070;
   localparam logic [8:0] OFF_DESC_LOW       = 9'h080;
   localparam logic [8:0] OFF_DESC_HIGH      = 9'h084;
   localparam logic [8:0] OFF_AVAIL_LOW      = 9'h090;
   localparam logic [8:0] OFF_AVAIL_HIGH     = 9'h094;
   localparam logic [8:0] OFF_USED_LOW       = 9'h0a0;
   localparam logic [8:0] OFF_USED_HIGH      = 9'h0a4;
   localparam logic [8:0] OFF_CONFIG_GEN     = 9'h0fc;

   // per-queue entry held in the queue RAM
   typedef struct packed {
      logic        ready;
      logic [31:0] pfn;
   } qentry_type;

   localparam int QENTRY_WIDTH = $bits(qentry_type);

endpackage

// ===== rtl/virtio_mmio_register_file_top.sv =====
// Device side of a virtio-mmio register window (version 1 legacy or version 2 modern layout,
// chosen by csr legacy_mode). Each request beat is one 32-bit register read, one register
// write, a device event raising interrupt status bits, or a no-op; each produces exactly one response
// beat carrying read data, the interrupt line after the access and an unmapped-access flag.
// A request is captured in an input register and resolved from there into the response
// register, so one beat is taken every cycle while the response side is free; the
// response register stalls the input register only when a response is held back.
// Per-queue page frame and ready bit live in a small RAM (one entry per queue, registered
// read) that always has the currently selected queue's entry on its read port; per-queue
// valid flip-flops make a status write of zero clear every queue at once, without a sweep.
// Queue size, ring addresses, alignment and guest page size are decoded and acknowledged but
// not retained, since nothing in this block reads them back. The user must write configuration
// through the csr port only while no beat is in flight; the block itself does not enforce it.
module virtio_mmio_register_file_top #(
   parameter int NUM_QUEUES = vmmio_pkg::NUM_QUEUES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wr_data,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [8:0]  req_reg_offset,
   input  logic [31:0] req_write_data,
   input  logic [1:0]  req_raise_bits,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_line,
   output logic        rsp_bad_access
);

   import vmmio_pkg::*;

   localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

   // configuration registers
   logic        legacy_ff;
   logic [31:0] device_id_ff;
   logic [31:0] dev_feat_low_ff;
   logic [31:0] dev_feat_high_ff;
   logic [15:0] queue_max_ff;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff;
   logic [8:0]  s1_off_ff;
   logic [31:0] s1_data_ff;
   logic [1:0]  s1_raise_ff;

   // response register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff, rsp_data_in;
   logic        rsp_irq_ff, rsp_irq_in;
   logic        rsp_bad_ff, rsp_bad_in;

   // transport state
   logic [7:0]            status_ff, status_in;
   logic                  dev_page_ff, dev_page_in;
   logic                  drv_page_ff, drv_page_in;
   logic [31:0]           drv_feat_ff [2];
   logic [31:0]           drv_feat_in [2];
   logic [15:0]           sel_ff, sel_in;
   logic [1:0]            irq_ff, irq_in;
   logic [NUM_QUEUES-1:0] qvalid_ff, qvalid_in;

   // selected-queue view: hold covers a just-written or just-cleared entry
   logic       hold_ff, hold_in;
   qentry_type hold_data_ff, hold_data_in;
   logic       rvalid_ff, rvalid_in;

   logic [QENTRY_WIDTH-1:0] ram_rdata;
   logic                    ram_we;
   qentry_type              ram_wdata;

   logic       adv2;
   logic       s1_fire;
   logic       req_accept;
   logic       leg;
   logic       qv;
   logic [QW-1:0] qidx;
   qentry_type cur;
   logic       mapped;
   logic       feat_ok;
   logic [7:0] new_status;
   logic       clear_all;
   logic [31:0] rd_val;

   // ---------------------------------------------------------------- handshake
   assign adv2       = !rsp_valid_ff || !rsp_stall;
   assign s1_fire    = s1_valid_ff && adv2;
   assign req_stall  = s1_valid_ff && !adv2;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (adv2) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = adv2 ? s1_valid_ff : rsp_valid_ff;
   end

   // ---------------------------------------------------------------- access logic
   assign leg  = legacy_ff;
   assign qv   = sel_ff < 16'(NUM_QUEUES);
   assign qidx = sel_ff[QW-1:0];
   assign cur  = hold_ff ? hold_data_ff
                         : (rvalid_ff ? qentry_type'(ram_rdata) : qentry_type'('0));

   assign feat_ok = ((drv_feat_ff[0] & ~dev_feat_low_ff) == 32'd0) &&
                    ((drv_feat_ff[1] & ~dev_feat_high_ff) == 32'd0) &&
                    (leg || drv_feat_ff[1][0]);

   always_comb begin
      status_in      = status_ff;
      dev_page_in    = dev_page_ff;
      drv_page_in    = drv_page_ff;
      drv_feat_in[0] = drv_feat_ff[0];
      drv_feat_in[1] = drv_feat_ff[1];
      sel_in         = sel_ff;
      irq_in         = irq_ff;
      qvalid_in      = qvalid_ff;
      hold_in        = hold_ff;
      hold_data_in   = hold_data_ff;
      ram_we         = 1'b0;
      ram_wdata      = cur;
      mapped         = 1'b1;
      rd_val         = 32'd0;
      clear_all      = 1'b0;
      new_status     = s1_data_ff[7:0];
      rsp_data_in    = 32'd0;
      rsp_bad_in     = 1'b0;

      if (s1_fire) begin
         if (s1_op_ff == OP_READ || s1_op_ff == OP_WRITE) begin
            if (s1_off_ff[1:0] != 2'd0) begin
               mapped = 1'b0;
            end else if (s1_off_ff[8]) begin
               // device config space: reads zero, writes ignored
               mapped = 1'b1;
            end else if (s1_op_ff == OP_READ) begin
               unique case (s1_off_ff)
                  OFF_MAGIC:         rd_val = MMIO_MAGIC;
                  OFF_VERSION:       rd_val = leg ? VERSION_LEGACY : VERSION_MODERN;
                  OFF_DEVICE_ID:     rd_val = device_id_ff;
                  OFF_DEV_FEAT:      rd_val = dev_page_ff ? dev_feat_high_ff : dev_feat_low_ff;
                  OFF_VENDOR_ID, OFF_DEV_FEAT_SEL, OFF_DRV_FEAT, OFF_DRV_FEAT_SEL,
                  OFF_QUEUE_SEL, OFF_QUEUE_NUM, OFF_QUEUE_NOTIFY, OFF_INT_ACK: begin
                     rd_val = 32'd0;
                  end
                  OFF_QUEUE_NUM_MAX: rd_val = qv ? {16'd0, queue_max_ff} : 32'd0;
                  OFF_INT_STATUS:    rd_val = {30'd0, irq_ff};
                  OFF_STATUS:        rd_val = {24'd0, status_ff};
                  OFF_GUEST_PAGE_SZ, OFF_QUEUE_ALIGN: mapped = leg;
                  OFF_QUEUE_PFN: begin
                     mapped = leg;
                     if (leg && qv) begin
                        rd_val = cur.pfn;
                     end
                  end
                  OFF_QUEUE_READY: begin
                     mapped = !leg;
                     if (!leg && qv) begin
                        rd_val = {31'd0, cur.ready};
                     end
                  end
                  OFF_DESC_LOW, OFF_DESC_HIGH, OFF_AVAIL_LOW, OFF_AVAIL_HIGH,
                  OFF_USED_LOW, OFF_USED_HIGH, OFF_CONFIG_GEN: begin
                     mapped = !leg;
                  end
                  default: mapped = 1'b0;
               endcase
            end else begin
               unique case (s1_off_ff)
                  OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID, OFF_DEV_FEAT,
                  OFF_QUEUE_NUM_MAX, OFF_QUEUE_NUM, OFF_QUEUE_NOTIFY, OFF_INT_STATUS: begin
                     mapped = 1'b1;
                  end
                  OFF_DEV_FEAT_SEL: dev_page_in = s1_data_ff[0];
                  OFF_DRV_FEAT:     drv_feat_in[drv_page_ff] = s1_data_ff;
                  OFF_DRV_FEAT_SEL: drv_page_in = s1_data_ff[0];
                  OFF_QUEUE_SEL: begin
                     sel_in  = s1_data_ff[15:0];
                     hold_in = 1'b0;
                  end
                  OFF_INT_ACK: irq_in = irq_ff & ~s1_data_ff[1:0];
                  OFF_STATUS: begin
                     if (new_status == 8'd0) begin
                        clear_all = 1'b1;
                     end else begin
                        if (!feat_ok) begin
                           new_status[STATUS_FEATURES_OK] = 1'b0;
                        end
                        status_in = new_status;
                     end
                  end
                  OFF_GUEST_PAGE_SZ, OFF_QUEUE_ALIGN: mapped = leg;
                  OFF_QUEUE_PFN: begin
                     mapped = leg;
                     if (leg && qv) begin
                        ram_we        = 1'b1;
                        ram_wdata.pfn = s1_data_ff;
                     end
                  end
                  OFF_QUEUE_READY: begin
                     mapped = !leg;
                     if (!leg && qv) begin
                        ram_we          = 1'b1;
                        ram_wdata.ready = s1_data_ff[0];
                     end
                  end
                  OFF_DESC_LOW, OFF_DESC_HIGH, OFF_AVAIL_LOW, OFF_AVAIL_HIGH,
                  OFF_USED_LOW, OFF_USED_HIGH, OFF_CONFIG_GEN: begin
                     mapped = !leg;
                  end
                  default: mapped = 1'b0;
               endcase
            end
            rsp_bad_in  = !mapped;
            rsp_data_in = (s1_op_ff == OP_READ && mapped) ? rd_val : 32'd0;
         end else if (s1_op_ff == OP_RAISE) begin
            irq_in = irq_ff | s1_raise_ff;
         end

         if (ram_we) begin
            qvalid_in[qidx] = 1'b1;
            hold_in         = 1'b1;
            hold_data_in    = ram_wdata;
         end

         if (clear_all) begin
            status_in      = 8'd0;
            dev_page_in    = 1'b0;
            drv_page_in    = 1'b0;
            drv_feat_in[0] = 32'd0;
            drv_feat_in[1] = 32'd0;
            sel_in         = 16'd0;
            irq_in         = 2'd0;
            qvalid_in      = '0;
            hold_in        = 1'b1;
            hold_data_in   = '0;
         end
      end

      rsp_irq_in = irq_in != 2'd0;
      rvalid_in  = (sel_in < 16'(NUM_QUEUES)) && qvalid_ff[sel_in[QW-1:0]];
   end

   vmmio_ram #(
      .DATA_WIDTH (QENTRY_WIDTH),
      .DEPTH      (NUM_QUEUES),
      .ADDR_WIDTH (QW)
   ) u_queue_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (qidx),
      .wr_data (ram_wdata),
      .rd_addr (sel_in[QW-1:0]),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         legacy_ff        <= 1'b0;
         device_id_ff     <= 32'd0;
         dev_feat_low_ff  <= 32'd0;
         dev_feat_high_ff <= 32'd1;
         queue_max_ff     <= 16'd128;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_LEGACY_MODE:    legacy_ff        <= csr_wr_data[0];
            CSR_DEVICE_ID:      device_id_ff     <= csr_wr_data;
            CSR_DEV_FEAT_LOW:   dev_feat_low_ff  <= csr_wr_data;
            CSR_DEV_FEAT_HIGH:  dev_feat_high_ff <= csr_wr_data;
            CSR_QUEUE_SIZE_MAX: queue_max_ff     <= csr_wr_data[15:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         status_ff      <= 8'd0;
         dev_page_ff    <= 1'b0;
         drv_page_ff    <= 1'b0;
         drv_feat_ff[0] <= 32'd0;
         drv_feat_ff[1] <= 32'd0;
         sel_ff         <= 16'd0;
         irq_ff         <= 2'd0;
         qvalid_ff      <= '0;
         hold_ff        <= 1'b1;
         hold_data_ff   <= '0;
         rvalid_ff      <= 1'b0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         status_ff      <= status_in;
         dev_page_ff    <= dev_page_in;
         drv_page_ff    <= drv_page_in;
         drv_feat_ff[0] <= drv_feat_in[0];
         drv_feat_ff[1] <= drv_feat_in[1];
         sel_ff         <= sel_in;
         irq_ff         <= irq_in;
         qvalid_ff      <= qvalid_in;
         hold_ff        <= hold_in;
         hold_data_ff   <= hold_data_in;
         rvalid_ff      <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= req_op;
         s1_off_ff   <= req_reg_offset;
         s1_data_ff  <= req_write_data;
         s1_raise_ff <= req_raise_bits;
      end
      if (s1_fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_irq_ff  <= rsp_irq_in;
         rsp_bad_ff  <= rsp_bad_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_data_ff;
   assign rsp_irq_line   = rsp_irq_ff;
   assign rsp_bad_access = rsp_bad_ff;

`ifndef SYNTHESIS
   a_bad_reads_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bad_ff |-> rsp_data_ff == 32'd0)
      else $error("unmapped access returned nonzero data");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff && rsp_stall)
      else $error("request stalled while response register free");

   a_irq_line_tracks_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_irq_ff == (irq_ff != 2'd0))
      else $error("held irq line disagrees with interrupt status");

   a_status_zero_clears: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_op_ff == OP_WRITE && s1_off_ff == OFF_STATUS &&
      s1_data_ff[7:0] == 8'd0
      |=> sel_ff == 16'd0 && irq_ff == 2'd0 && qvalid_ff == '0 && status_ff == 8'd0)
      else $error("status write of zero did not clear transport state");
`endif

endmodule

// ===== rtl/vmmio_ram.sv =====
module vmmio_ram #(
   parameter int DATA_WIDTH = 33,
   parameter int DEPTH      = 8,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== verif/tb_virtio_mmio_register_file_top.sv =====
`timescale 1ns / 1ps

module tb_virtio_mmio_register_file_top;
   import vmmio_pkg::*;

   localparam int NQ           = NUM_QUEUES_DEFAULT;
   localparam int DRAIN_CYCLES = 4;        // input and response registers plus margin
   localparam int HOLD_CYCLES  = 60;       // long response hold-off, fills the pipe
   localparam int PHASE_BEATS  = 240;
   localparam int TIMEOUT_NS   = 1_200_000; // far above the slowest run

   // status byte bits as the driver sets them during bring-up
   localparam logic [7:0] ST_ACK     = 8'h01;
   localparam logic [7:0] ST_DRV     = 8'h02;
   localparam logic [7:0] ST_DRV_OK  = 8'h04;
   localparam logic [7:0] ST_FEAT_OK = 8'h01 << STATUS_FEATURES_OK;

   localparam logic [31:0] GUEST_PAGE   = 32'd4096;
   localparam logic [8:0]  OFF_UNMAPPED = 9'h018;
   localparam logic [8:0]  OFF_CFG_LAST = 9'h1fc;

   typedef struct packed {
      op_type      op;
      logic [8:0]  offset;
      logic [31:0] data;
      logic [1:0]  raise;
   } access_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_line;
      logic        bad_access;
   } response_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [2:0]  csr_index   = '0;
   logic [31:0] csr_wr_data = '0;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [1:0]  req_op;
   logic [8:0]  req_reg_offset;
   logic [31:0] req_write_data;
   logic [1:0]  req_raise_bits;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic [31:0] rsp_read_data;
   logic        rsp_irq_line;
   logic        rsp_bad_access;

   access_type cur_access = '{OP_NONE, 9'h0, 32'h0, 2'h0};

   assign req_op         = cur_access.op;
   assign req_reg_offset = cur_access.offset;
   assign req_write_data = cur_access.data;
   assign req_raise_bits = cur_access.raise;

   virtio_mmio_register_file_top dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_reg_offset (req_reg_offset),
      .req_write_data (req_write_data),
      .req_raise_bits (req_raise_bits),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq_line   (rsp_irq_line),
      .rsp_bad_access (rsp_bad_access)
   );

   // ---------------------------------------------------------------------
   // Register settings as last written through the csr port
   // ---------------------------------------------------------------------
   logic        cfg_legacy  = 1'b0;
   logic [31:0] cfg_dev_id  = '0;
   logic [31:0] cfg_feat_lo = '0;
   logic [31:0] cfg_feat_hi = 32'h1;
   logic [15:0] cfg_qmax    = 16'd128;

   // ---------------------------------------------------------------------
   // Transport state as the driver sees it. Queue size, ring addresses,
   // alignment and guest page size never read back, so they are not kept.
   // ---------------------------------------------------------------------
   logic [7:0]  m_status;
   logic        m_dev_page;
   logic        m_drv_page;
   logic [31:0] m_drv_feat [2];
   logic [15:0] m_queue_sel;
   logic [31:0] m_pfn [NQ];
   logic [NQ-1:0] m_ready;
   logic [1:0]  m_irq;

   access_type   pending_req[$];    // accesses waiting to be driven
   response_type due_responses[$];  // responses owed by the block, oldest first

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  hold_armed    = 0;
   bit  beat_taken    = 0;
   int  pushed        = 0;
   int  beats_in      = 0;
   int  responses_seen = 0;
   int  mismatches    = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #TIMEOUT_NS;
      $display("Simulation FAILED");
      $finish;
   end

   // status write of zero, and reset, clear everything but the registers
   function automatic void clear_transport();
      m_status    = '0;
      m_dev_page  = 1'b0;
      m_drv_page  = 1'b0;
      m_drv_feat[0] = '0;
      m_drv_feat[1] = '0;
      m_queue_sel = '0;
      m_ready     = '0;
      m_irq       = '0;
      foreach (m_pfn[i]) m_pfn[i] = '0;
   endfunction

   // Applies one access to the transport state and returns its response.
   function automatic response_type predict_access(access_type a);
      response_type r;
      logic       leg, qv, hit, ok;
      int         qi;
      logic [7:0] s;
      leg = cfg_legacy;
      qv  = m_queue_sel < NQ;
      qi  = qv ? int'(m_queue_sel) : 0;
      r   = '{32'h0, 1'b0, 1'b0};
      hit = 1'b1;
      if (a.op == OP_READ || a.op == OP_WRITE) begin
         if (a.offset[1:0] != 2'b00) begin
            hit = 1'b0;
         end else if (a.offset[8]) begin
            hit = 1'b1;   // device config space: reads zero, writes dropped
         end else if (a.op == OP_READ) begin
            case (a.offset)
               OFF_MAGIC:         r.read_data = MMIO_MAGIC;
               OFF_VERSION:       r.read_data = leg ? VERSION_LEGACY : VERSION_MODERN;
               OFF_DEVICE_ID:     r.read_data = cfg_dev_id;
               OFF_DEV_FEAT:      r.read_data = m_dev_page ? cfg_feat_hi : cfg_feat_lo;
               OFF_QUEUE_NUM_MAX: r.read_data = qv ? {16'h0, cfg_qmax} : 32'h0;
               OFF_INT_STATUS:    r.read_data = {30'h0, m_irq};
               OFF_STATUS:        r.read_data = {24'h0, m_status};
               OFF_VENDOR_ID, OFF_DEV_FEAT_SEL, OFF_DRV_FEAT, OFF_DRV_FEAT_SEL,
               OFF_QUEUE_SEL, OFF_QUEUE_NUM, OFF_QUEUE_NOTIFY, OFF_INT_ACK:
                  hit = 1'b1;
               OFF_GUEST_PAGE_SZ, OFF_QUEUE_ALIGN:
                  hit = leg;
               OFF_QUEUE_PFN: begin
                  hit = leg;
                  if (leg && qv) r.read_data = m_pfn[qi];
               end
               OFF_QUEUE_READY: begin
                  hit = !leg;
                  if (!leg && qv) r.read_data = {31'h0, m_ready[qi]};
               end
               OFF_DESC_LOW, OFF_DESC_HIGH, OFF_AVAIL_LOW, OFF_AVAIL_HIGH,
               OFF_USED_LOW, OFF_USED_HIGH, OFF_CONFIG_GEN:
                  hit = !leg;
               default: hit = 1'b0;
            endcase
         end else begin
            case (a.offset)
               OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID, OFF_DEV_FEAT,
               OFF_QUEUE_NUM_MAX, OFF_QUEUE_NOTIFY, OFF_INT_STATUS, OFF_QUEUE_NUM:
                  hit = 1'b1;
               OFF_DEV_FEAT_SEL: m_dev_page = a.data[0];
               OFF_DRV_FEAT:     m_drv_feat[m_drv_page] = a.data;
               OFF_DRV_FEAT_SEL: m_drv_page = a.data[0];
               OFF_QUEUE_SEL:    m_queue_sel = a.data[15:0];
               OFF_INT_ACK:      m_irq = m_irq & ~a.data[1:0];
               OFF_STATUS: begin
                  s = a.data[7:0];
                  if (s == 8'h0) begin
                     clear_transport();
                  end else begin
                     if (s[STATUS_FEATURES_OK]) begin
                        ok = ((m_drv_feat[0] & ~cfg_feat_lo) == 32'h0) &&
                             ((m_drv_feat[1] & ~cfg_feat_hi) == 32'h0) &&
                             (leg || m_drv_feat[1][0]);
                        if (!ok) s[STATUS_FEATURES_OK] = 1'b0;
                     end
                     m_status = s;
                  end
               end
               OFF_GUEST_PAGE_SZ, OFF_QUEUE_ALIGN:
                  hit = leg;
               OFF_QUEUE_PFN: begin
                  hit = leg;
                  if (leg && qv) m_pfn[qi] = a.data;
               end
               OFF_QUEUE_READY: begin
                  hit = !leg;
                  if (!leg && qv) m_ready[qi] = a.data[0];
               end
               OFF_DESC_LOW, OFF_DESC_HIGH, OFF_AVAIL_LOW, OFF_AVAIL_HIGH,
               OFF_USED_LOW, OFF_USED_HIGH, OFF_CONFIG_GEN:
                  hit = !leg;
               default: hit = 1'b0;
            endcase
         end
      end else if (a.op == OP_RAISE) begin
         m_irq = m_irq | a.raise;
      end
      if (a.op != OP_READ || !hit) r.read_data = 32'h0;
      r.bad_access = !hit;
      r.irq_line   = |m_irq;
      return r;
   endfunction

   task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at response %0d: %s got %h want %h",
               responses_seen, what, got, want);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------
   // Request driver: changes on the falling edge; a beat stays on the pins
   // until the rising edge that takes it, so payload never moves under stall.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || beat_taken) begin
         if (pending_req.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            cur_access <= pending_req.pop_front();
            req_valid  <= 1'b1;
         end else begin
            req_valid  <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response stall: random back-pressure, plus one long hold-off that lets
   // the block fill and push back on the request side.
   // ---------------------------------------------------------------------
   int hold_left = 0;
   bit hold_done = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_armed && !hold_done) begin
         hold_done = 1;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: on each rising edge log the taken request beat (its response
   // is worked out now, in order) and check any response beat taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      response_type due;
      if (reset) begin
         beat_taken = 0;
      end else begin
         beat_taken = req_valid && !req_stall;
         if (beat_taken) begin
            due_responses.push_back(predict_access(cur_access));
            beats_in++;
         end
         if (rsp_valid && !rsp_stall) begin
            responses_seen++;
            if (due_responses.size() == 0) begin
               note_mismatch("response with none owed", rsp_read_data, 32'h0);
            end else begin
               due = due_responses.pop_front();
               if (rsp_read_data !== due.read_data)
                  note_mismatch("read_data", rsp_read_data, due.read_data);
               if (rsp_irq_line !== due.irq_line)
                  note_mismatch("irq_line", {31'h0, rsp_irq_line}, {31'h0, due.irq_line});
               if (rsp_bad_access !== due.bad_access)
                  note_mismatch("bad_access", {31'h0, rsp_bad_access},
                                {31'h0, due.bad_access});
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic push_beat(op_type op, logic [8:0] off, logic [31:0] data,
                            logic [1:0] raise);
      access_type a;
      a.op     = op;
      a.offset = off;
      a.data   = data;
      a.raise  = raise;
      pending_req.push_back(a);
      pushed++;
   endtask

   // don't-care fields carry random bits so every pin toggles
   task automatic push_read(logic [8:0] off);
      push_beat(OP_READ, off, $urandom(), 2'($urandom_range(3, 0)));
   endtask

   task automatic push_write(logic [8:0] off, logic [31:0] data);
      push_beat(OP_WRITE, off, data, 2'($urandom_range(3, 0)));
   endtask

   task automatic push_raise(logic [1:0] bits);
      push_beat(OP_RAISE, 9'($urandom_range(511, 0)), $urandom(), bits);
   endtask

   function automatic logic [8:0] pick_register();
      case ($urandom_range(26, 0))
         0:  return OFF_MAGIC;          1:  return OFF_VERSION;
         2:  return OFF_DEVICE_ID;      3:  return OFF_VENDOR_ID;
         4:  return OFF_DEV_FEAT;       5:  return OFF_DEV_FEAT_SEL;
         6:  return OFF_DRV_FEAT;       7:  return OFF_DRV_FEAT_SEL;
         8:  return OFF_GUEST_PAGE_SZ;  9:  return OFF_QUEUE_SEL;
         10: return OFF_QUEUE_NUM_MAX;  11: return OFF_QUEUE_NUM;
         12: return OFF_QUEUE_ALIGN;    13: return OFF_QUEUE_PFN;
         14: return OFF_QUEUE_READY;    15: return OFF_QUEUE_NOTIFY;
         16: return OFF_INT_STATUS;     17: return OFF_INT_ACK;
         18: return OFF_STATUS;         19: return OFF_DESC_LOW;
         20: return OFF_DESC_HIGH;      21: return OFF_AVAIL_LOW;
         22: return OFF_AVAIL_HIGH;     23: return OFF_USED_LOW;
         24: return OFF_USED_HIGH;      25: return OFF_CONFIG_GEN;
         default: return OFF_CFG_LAST;
      endcase
   endfunction

   // Mostly driver bring-up sequences with random content (reset, feature
   // negotiation, queue setup, interrupt handling), the rest single noise beats.
   task automatic push_random(int n);
      int          stop;
      logic [31:0] v, sel;
      logic [8:0]  off;
      stop = pushed + n;
      while (pushed < stop) begin
         if ($urandom_range(99, 0) < 60) begin
            if ($urandom_range(3, 0) != 0) push_write(OFF_STATUS, 32'h0);
            push_write(OFF_STATUS, 32'(ST_ACK));
            push_write(OFF_STATUS, 32'(ST_ACK | ST_DRV));
            push_write(OFF_DEV_FEAT_SEL, $urandom_range(3, 0));
            push_read(OFF_DEV_FEAT);
            push_write(OFF_DRV_FEAT_SEL, $urandom() & 32'hffff_fffe);
            v = $urandom_range(1, 0) ? (cfg_feat_lo & $urandom()) : $urandom();
            push_write(OFF_DRV_FEAT, v);
            push_write(OFF_DRV_FEAT_SEL, $urandom() | 32'h1);
            v = $urandom_range(1, 0) ? (cfg_feat_hi & $urandom()) : $urandom();
            if ($urandom_range(1, 0)) v[0] = 1'b1;
            push_write(OFF_DRV_FEAT, v);
            push_write(OFF_STATUS, $urandom_range(1, 0) ? 32'(ST_ACK | ST_DRV | ST_FEAT_OK)
                                                          : ($urandom() | ST_FEAT_OK));
            push_read(OFF_STATUS);
            repeat ($urandom_range(3, 1)) begin
               case ($urandom_range(7, 0))
                  0:       sel = NQ;
                  1:       sel = $urandom_range(16'hffff, NQ);
                  2:       sel = $urandom();   // upper half is dropped
                  default: sel = $urandom_range(NQ - 1, 0);
               endcase
               push_write(OFF_QUEUE_SEL, sel);
               push_read(OFF_QUEUE_NUM_MAX);
               push_write(OFF_QUEUE_NUM, $urandom_range(1, 0) ? $urandom_range(cfg_qmax, 0)
                                                               : $urandom());
               if (cfg_legacy) begin
                  push_read(OFF_QUEUE_PFN);
                  push_write(OFF_GUEST_PAGE_SZ, GUEST_PAGE);
                  push_write(OFF_QUEUE_ALIGN, $urandom());
                  push_write(OFF_QUEUE_PFN, $urandom());
                  push_read(OFF_QUEUE_PFN);
               end else begin
                  push_read(OFF_QUEUE_READY);
                  push_write(OFF_DESC_LOW, $urandom());
                  push_write(OFF_DESC_HIGH, $urandom());
                  push_write(OFF_AVAIL_LOW, $urandom());
                  push_write(OFF_AVAIL_HIGH, $urandom());
                  push_write(OFF_USED_LOW, $urandom());
                  push_write(OFF_USED_HIGH, $urandom());
                  push_write(OFF_QUEUE_READY, $urandom());
                  push_read(OFF_QUEUE_READY);
               end
               if ($urandom_range(1, 0)) push_write(OFF_QUEUE_NOTIFY, sel);
            end
            if ($urandom_range(1, 0)) begin
               push_raise(2'($urandom_range(3, 0)));
               push_read(OFF_INT_STATUS);
               push_write(OFF_INT_ACK, $urandom());
               push_read(OFF_INT_STATUS);
            end
            push_write(OFF_STATUS, 32'(ST_ACK | ST_DRV | ST_FEAT_OK | ST_DRV_OK));
            push_read(OFF_STATUS);
         end else begin
            case ($urandom_range(9, 0))
               0, 1, 2, 3, 4: off = pick_register();
               5, 6, 7:       off = 9'($urandom_range(511, 0));  // often unaligned
               default:       off = 9'($urandom_range(127, 0) << 2);
            endcase
            case ($urandom_range(9, 0))
               0, 1:    v = 32'h0;
               2:       v = 32'hffff_ffff;
               default: v = $urandom();
            endcase
            push_beat(op_type'($urandom_range(3, 0)), off, v, 2'($urandom_range(3, 0)));
         end
      end
   endtask

   // nothing queued, nothing in the pipe, nothing owed
   task automatic wait_idle();
      while (pending_req.size() != 0 || req_valid || due_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_LEGACY_MODE:    cfg_legacy  = value[0];
         CSR_DEVICE_ID:      cfg_dev_id  = value;
         CSR_DEV_FEAT_LOW:   cfg_feat_lo = value;
         CSR_DEV_FEAT_HIGH:  cfg_feat_hi = value;
         CSR_QUEUE_SIZE_MAX: cfg_qmax    = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // new register setting and idle mix, only once the block has gone quiet
   task automatic configure(logic legacy, logic [31:0] id, logic [31:0] flo,
                            logic [31:0] fhi, logic [15:0] qmax, int sidle, int ridle);
      wait_idle();
      write_csr(CSR_LEGACY_MODE, {31'h0, legacy});
      write_csr(CSR_DEVICE_ID, id);
      write_csr(CSR_DEV_FEAT_LOW, flo);
      write_csr(CSR_DEV_FEAT_HIGH, fhi);
      write_csr(CSR_QUEUE_SIZE_MAX, {16'h0, qmax});
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      clear_transport();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // modern layout, directed corners first
      configure(1'b0, 32'h1, 32'h3000_00ff, 32'h1, 16'd128, 25, 60);
      push_read(OFF_MAGIC);
      push_read(OFF_VERSION);
      push_read(OFF_DEVICE_ID);
      push_read(OFF_VENDOR_ID);
      push_read(OFF_VERSION | 9'h2);                  // unaligned
      push_write(OFF_UNMAPPED, 32'hffff_ffff);        // hole in the map
      push_read(OFF_CFG_LAST);                        // config space reads zero
      push_write(OFF_DEV_FEAT_SEL, 32'd3);            // page select wraps to 1
      push_read(OFF_DEV_FEAT);
      push_write(OFF_DRV_FEAT_SEL, 32'd1);
      push_write(OFF_DRV_FEAT, 32'd1);                // VERSION_1 only
      push_write(OFF_STATUS, 32'(ST_ACK | ST_DRV | ST_FEAT_OK));
      push_read(OFF_STATUS);
      push_write(OFF_QUEUE_SEL, NQ);                  // no such queue
      push_read(OFF_QUEUE_NUM_MAX);
      push_write(OFF_QUEUE_SEL, 32'd0);
      push_write(OFF_QUEUE_NUM, 32'hffff_ffff);       // above max, dropped
      push_write(OFF_QUEUE_READY, 32'h1);
      push_read(OFF_QUEUE_READY);
      push_read(OFF_QUEUE_PFN);                       // legacy only, absent here
      push_raise(2'b11);
      push_write(OFF_INT_ACK, 32'h1);
      push_read(OFF_INT_STATUS);
      push_write(OFF_STATUS, 32'h0);                  // full transport reset
      push_read(OFF_QUEUE_READY);
      push_beat(OP_NONE, OFF_STATUS, 32'h0, 2'b11);
      push_random(PHASE_BEATS - 26);

      // legacy, id and feature registers all ones, queue max 32768
      configure(1'b1, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 16'd32768, 25, 60);
      push_random(PHASE_BEATS);

      // modern with nothing offered: FEATURES_OK can never stick;
      // sender pauses half-way until every response is back
      configure(1'b0, 32'h0, 32'h0, 32'h0, 16'd0, 60, 25);
      push_random(PHASE_BEATS / 2);
      wait_idle();
      push_random(PHASE_BEATS / 2);

      configure(1'b1, $urandom(), $urandom(), $urandom(), 16'd1, 60, 25);
      push_random(PHASE_BEATS);

      // back to back, with one long response hold-off while requests keep coming
      configure(1'b0, $urandom(), $urandom(), $urandom() | 32'h1,
                16'($urandom_range(32768, 0)), 0, 0);
      push_random(PHASE_BEATS);
      hold_armed = 1;

      configure(1'b1, 32'h0, 32'h0, 32'h0, 16'd0, 0, 0);
      push_random(PHASE_BEATS);

      wait_idle();
      $display("Covered %0d register accesses and interrupt events over six settings of",
               beats_in);
      $display("both layouts, with random stalls and a %0d-cycle hold-off; %0d mismatches.",
               HOLD_CYCLES, mismatches);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
